/* design/telemetry_frame_builder_defines.svh */
// Assertion macros for the design files; tfb_out_buffer.sv uses them.
// Each macro builds a labelled concurrent assertion on the rising clock edge,
// disabled while the active-low reset is asserted.
`ifndef TELEMETRY_FRAME_BUILDER_DEFINES_SVH
`define TELEMETRY_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication.
`define TFB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfb: same-cycle check failed");

// Next-cycle implication.
`define TFB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfb: next-cycle check failed");

`endif

/* design/tfb_pkg.sv */
package tfb_pkg;

  typedef logic [7:0] byte_t;

  // Largest number of result bytes that one request can cause.
  localparam int unsigned MaxResults = 6;
  localparam int unsigned CountW     = 3;

  localparam byte_t FrameHead   = 8'hAA;
  localparam byte_t DestReset   = 8'hFF;

  // Request operation codes.
  localparam logic OpStart = 1'b0;
  localparam logic OpData  = 1'b1;

  // Result counts for the possible request outcomes.
  localparam logic [CountW-1:0] CountNone         = 3'd0;
  localparam logic [CountW-1:0] CountData         = 3'd1;
  localparam logic [CountW-1:0] CountDataChecks   = 3'd3;
  localparam logic [CountW-1:0] CountHeader       = 3'd4;
  localparam logic [CountW-1:0] CountHeaderChecks = 3'd6;

  // The bytes one request produces; entry 0 goes out first.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
    logic                       closes;
  } frame_result_t;

endpackage

/* design/tfb_frame_logic.sv */
// Frame state and the combinational pass that turns one request into its
// result bytes.
module tfb_frame_logic #(
  parameter int unsigned MAX_PAYLOAD = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic                  op_i,
  input  tfb_pkg::byte_t        func_code_i,
  input  tfb_pkg::byte_t        frame_len_i,
  input  tfb_pkg::byte_t        data_byte_i,
  input  tfb_pkg::byte_t        dest_address_i,
  output tfb_pkg::frame_result_t result_o
);

  localparam int unsigned LenW = $clog2(MAX_PAYLOAD + 1);

  logic                frame_open_q, frame_open_d;
  logic [LenW-1:0]     bytes_left_q, bytes_left_d;
  tfb_pkg::byte_t      sum_check_q, sum_check_d;
  tfb_pkg::byte_t      add_check_q, add_check_d;

  tfb_pkg::byte_t      s1, s2, s3, s4, a2, a3, a4;
  tfb_pkg::byte_t      ds, da;
  logic [LenW-1:0]     left_dec;
  logic                oversize;

  // Header running sums always start from zero.
  assign s1 = tfb_pkg::FrameHead;
  assign s2 = s1 + dest_address_i;
  assign a2 = s1 + s2;
  assign s3 = s2 + func_code_i;
  assign a3 = a2 + s3;
  assign s4 = s3 + frame_len_i;
  assign a4 = a3 + s4;

  assign ds = sum_check_q + data_byte_i;
  assign da = add_check_q + ds;

  assign left_dec = (bytes_left_q != '0) ? bytes_left_q - 1'b1 : bytes_left_q;
  assign oversize = {1'b0, frame_len_i} > 9'(MAX_PAYLOAD);

  always_comb begin
    result_o     = '0;
    frame_open_d = frame_open_q;
    bytes_left_d = bytes_left_q;
    sum_check_d  = sum_check_q;
    add_check_d  = add_check_q;
    if (fire_i) begin
      if (op_i == tfb_pkg::OpStart) begin
        if (!oversize) begin
          result_o.bytes[0] = tfb_pkg::FrameHead;
          result_o.bytes[1] = dest_address_i;
          result_o.bytes[2] = func_code_i;
          result_o.bytes[3] = frame_len_i;
          sum_check_d       = s4;
          add_check_d       = a4;
          if (frame_len_i == '0) begin
            result_o.bytes[4] = s4;
            result_o.bytes[5] = a4;
            result_o.count    = tfb_pkg::CountHeaderChecks;
            result_o.closes   = 1'b1;
            frame_open_d      = 1'b0;
            bytes_left_d      = '0;
          end else begin
            result_o.count    = tfb_pkg::CountHeader;
            frame_open_d      = 1'b1;
            bytes_left_d      = frame_len_i[LenW-1:0];
          end
        end
      end else if (frame_open_q) begin
        result_o.bytes[0] = data_byte_i;
        sum_check_d       = ds;
        add_check_d       = da;
        if (left_dec == '0) begin
          result_o.bytes[1] = ds;
          result_o.bytes[2] = da;
          result_o.count    = tfb_pkg::CountDataChecks;
          result_o.closes   = 1'b1;
          frame_open_d      = 1'b0;
          bytes_left_d      = '0;
        end else begin
          result_o.count    = tfb_pkg::CountData;
          bytes_left_d      = left_dec;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      bytes_left_q <= '0;
      sum_check_q  <= '0;
      add_check_q  <= '0;
    end else begin
      frame_open_q <= frame_open_d;
      bytes_left_q <= bytes_left_d;
      sum_check_q  <= sum_check_d;
      add_check_q  <= add_check_d;
    end
  end

endmodule

/* design/tfb_out_buffer.sv */
`include "telemetry_frame_builder_defines.svh"

// Result register: holds the bytes of one request and hands them out one a
// cycle while out_stall_i is low, shifting towards entry 0.
module tfb_out_buffer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  tfb_pkg::frame_result_t result_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tfb_pkg::byte_t         out_byte_o,
  output logic                   frame_end_o
);

  localparam int unsigned Depth = tfb_pkg::MaxResults;

  tfb_pkg::byte_t                bytes_q [Depth];
  logic [tfb_pkg::CountW-1:0]    count_q;
  logic                          closes_q;
  logic                          take;
  logic                          last_take;

  assign out_valid_o = count_q != tfb_pkg::CountNone;
  assign take        = out_valid_o && !out_stall_i;
  assign free_o      = !out_valid_o || (count_q == tfb_pkg::CountData && take);
  assign out_byte_o  = bytes_q[0];
  assign frame_end_o = closes_q && count_q == tfb_pkg::CountData;
  assign last_take   = take && count_q == tfb_pkg::CountData && !load_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= tfb_pkg::CountNone;
      closes_q <= 1'b0;
    end else if (load_i) begin
      count_q  <= result_i.count;
      closes_q <= result_i.closes;
    end else if (take) begin
      count_q  <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < Depth; i++) begin
        bytes_q[i] <= result_i.bytes[i];
      end
    end else if (take) begin
      for (int i = 0; i < Depth - 1; i++) begin
        bytes_q[i] <= bytes_q[i+1];
      end
    end
  end

  `TFB_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, load_i, free_o)
  `TFB_ASSERT_IMP(a_end_needs_valid, clk_i, rst_ni, frame_end_o, out_valid_o)
  `TFB_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= tfb_pkg::CountHeaderChecks)
  `TFB_ASSERT_NXT(a_drain_last, clk_i, rst_ni, last_take, count_q == tfb_pkg::CountNone)

endmodule

/* design/telemetry_frame_builder.sv */
// Telemetry frame builder.
// Requests arrive on the input channel (in_valid_i / in_stall_o): op_i low
// starts a frame with func_code_i and frame_len_i, op_i high carries one
// payload byte in data_byte_i. Frame bytes leave on the output channel
// (out_valid_o / out_stall_i) as out_byte_o, with frame_end_o marking the
// add-check byte that closes a frame. A request moves when valid is high and
// stall is low. The destination byte is written through cfg_we_i/cfg_wdata_i.
// A start request yields four header bytes (six when its length is zero), a
// payload request one byte (three when it is the last one); an oversized
// start or a stray payload byte yields nothing.
// The first byte of a request passes the input register and then the result
// register before it is offered. Throughput is one output byte per cycle
// while out_stall_i is low, set by the result register's single-byte
// output port, so payload requests stream at one per cycle.
// When the receiver stalls, the result register holds its byte and the
// input register fills, after which in_stall_o is raised.
// Reset clears the frame state and the buffers and sets the destination
// byte to 0xFF; no clearing pass is needed.
module telemetry_frame_builder #(
  parameter int unsigned MAX_PAYLOAD = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  tfb_pkg::byte_t        cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  tfb_pkg::byte_t        func_code_i,
  input  tfb_pkg::byte_t        frame_len_i,
  input  tfb_pkg::byte_t        data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tfb_pkg::byte_t        out_byte_o,
  output logic                  frame_end_o
);

  tfb_pkg::byte_t         dest_address_q;
  logic                   in_valid_q, in_valid_d;
  logic                   op_q;
  tfb_pkg::byte_t         func_code_q, frame_len_q, data_byte_q;
  logic                   accept;
  logic                   process;
  logic                   buf_free;
  tfb_pkg::frame_result_t result;

  // The input register gives way as soon as the result register can take its
  // request, so a new request can enter in every cycle that buf_free is high.
  assign process    = in_valid_q && buf_free;
  assign in_stall_o = in_valid_q && !buf_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (process) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      dest_address_q <= tfb_pkg::DestReset;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        dest_address_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= op_i;
      func_code_q <= func_code_i;
      frame_len_q <= frame_len_i;
      data_byte_q <= data_byte_i;
    end
  end

  tfb_frame_logic #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_frame_logic (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (process),
    .op_i           (op_q),
    .func_code_i    (func_code_q),
    .frame_len_i    (frame_len_q),
    .data_byte_i    (data_byte_q),
    .dest_address_i (dest_address_q),
    .result_o       (result)
  );

  tfb_out_buffer u_out_buffer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (process),
    .result_i    (result),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule

/* bench/telemetry_frame_builder_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the telemetry frame builder.
//
// An initial block fills a queue of pending requests, phase by phase. A clocked
// driver offers them on the input channel at the falling edge, and a clocked
// receiver works the output stall at the falling edge as well. The monitor
// samples both channels at the rising edge. Every accepted request goes through
// a local predictor of the framing logic. The bytes that the predictor expects
// queue up, and each accepted output byte is compared with the oldest of them.
// Between phases the bench drains the block and lets it settle; before most
// phases it then rewrites the destination byte.
module telemetry_frame_builder_tb;

  localparam int MaxPayload = 30;
  // Length of the deliberate receiver hold-off, long enough to back the block up.
  localparam int HoldCycles = 300;
  // Extra cycles after draining; a stray request may still sit in the pipeline.
  localparam int SettleCycles = 10;

  typedef struct packed {
    logic           op;
    tfb_pkg::byte_t func;
    tfb_pkg::byte_t len;
    tfb_pkg::byte_t data;
  } frame_request_t;

  typedef struct {
    tfb_pkg::byte_t value;
    logic           closes;
  } frame_byte_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_we_i = 1'b0;
  tfb_pkg::byte_t cfg_wdata_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  logic           op_i = tfb_pkg::OpStart;
  tfb_pkg::byte_t func_code_i = '0;
  tfb_pkg::byte_t frame_len_i = '0;
  tfb_pkg::byte_t data_byte_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  tfb_pkg::byte_t out_byte_o;
  logic           frame_end_o;

  telemetry_frame_builder #(
    .MAX_PAYLOAD(MaxPayload)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .func_code_i(func_code_i),
    .frame_len_i(frame_len_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .frame_end_o(frame_end_o)
  );

  always #5 clk = ~clk;

  // Stimulus still to be offered, and the frame bytes still owed by the block.
  frame_request_t pending_requests[$];
  frame_byte_t    due_bytes[$];
  int             fails = 0;

  // When clear, neither side inserts gaps, giving stretches at full rate.
  bit idle_on = 1'b1;
  // Each increment asks the receiver for one long hold-off.
  int hold_asks = 0;

  // Handshake results of the last rising edge, for the falling-edge processes.
  logic req_took = 1'b0;
  logic byte_took = 1'b0;

  // Shadow of the block's frame state and destination register.
  tfb_pkg::byte_t dest_q = tfb_pkg::DestReset;
  logic           open_q = 1'b0;
  logic [4:0]     left_q = '0;
  tfb_pkg::byte_t run_sum = '0;
  tfb_pkg::byte_t run_add = '0;

  function automatic int idle_draw();
    return idle_on ? $urandom_range(0, 10) : 0;
  endfunction

  function automatic void emit(tfb_pkg::byte_t b, logic fin);
    frame_byte_t e;
    e.value  = b;
    e.closes = fin;
    due_bytes.push_back(e);
  endfunction

  // Every header and payload byte feeds both running checks.
  function automatic void emit_tracked(tfb_pkg::byte_t b);
    run_sum = run_sum + b;
    run_add = run_add + run_sum;
    emit(b, 1'b0);
  endfunction

  // The sum check, then the add check that closes the frame.
  function automatic void emit_checks();
    emit(run_sum, 1'b0);
    emit(run_add, 1'b1);
    open_q = 1'b0;
    left_q = '0;
  endfunction

  function automatic void predict_frame_bytes(frame_request_t r);
    if (r.op == tfb_pkg::OpStart) begin
      // An oversized start is dropped and leaves any open frame alone.
      if (r.len > MaxPayload) return;
      // A valid start abandons an open frame without its check bytes.
      run_sum = '0;
      run_add = '0;
      emit_tracked(tfb_pkg::FrameHead);
      emit_tracked(dest_q);
      emit_tracked(r.func);
      emit_tracked(r.len);
      open_q = 1'b1;
      left_q = r.len[4:0];
      // An empty payload closes the frame straight after the header.
      if (r.len == 0) emit_checks();
    end else begin
      // Payload bytes outside an open frame are ignored.
      if (!open_q) return;
      emit_tracked(r.data);
      if (left_q > 0) left_q = left_q - 1'b1;
      if (left_q == 0) emit_checks();
    end
  endfunction

  // Fields that the operation does not use are filled at random all the same.
  task automatic push_start(tfb_pkg::byte_t func, tfb_pkg::byte_t len);
    frame_request_t r;
    r.op   = tfb_pkg::OpStart;
    r.func = func;
    r.len  = len;
    r.data = tfb_pkg::byte_t'($urandom);
    pending_requests.push_back(r);
  endtask

  task automatic push_data(tfb_pkg::byte_t d);
    frame_request_t r;
    r.op   = tfb_pkg::OpData;
    r.func = tfb_pkg::byte_t'($urandom);
    r.len  = tfb_pkg::byte_t'($urandom);
    r.data = d;
    pending_requests.push_back(r);
  endtask

  // Mostly complete frames with random content; the rest truncated frames,
  // oversized starts and stray payload bytes.
  task automatic push_random_frames(int n);
    int added;
    int pick;
    int len;
    int cut;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if (pick < 5) len = MaxPayload;
        else if (pick < 15) len = $urandom_range(0, MaxPayload);
        else len = $urandom_range(0, 6);
        push_start(tfb_pkg::byte_t'($urandom), tfb_pkg::byte_t'(len));
        repeat (len) push_data(tfb_pkg::byte_t'($urandom));
        added += len + 1;
      end else if (pick < 85) begin
        len = $urandom_range(1, MaxPayload);
        cut = $urandom_range(0, len - 1);
        push_start(tfb_pkg::byte_t'($urandom), tfb_pkg::byte_t'(len));
        repeat (cut) push_data(tfb_pkg::byte_t'($urandom));
        added += cut + 1;
      end else if (pick < 93) begin
        push_start(tfb_pkg::byte_t'($urandom),
                   tfb_pkg::byte_t'($urandom_range(MaxPayload + 1, 255)));
        added++;
      end else begin
        push_data(tfb_pkg::byte_t'($urandom));
        added++;
      end
    end
  endtask

  // The sender stops until every owed byte has arrived and the block is quiet.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid_i || due_bytes.size() != 0)
      @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_dest(tfb_pkg::byte_t v);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= tfb_pkg::byte_t'($urandom);
  endtask

  // Sender: a stalled request is held unchanged; otherwise the next one is
  // offered once its drawn gap has run out.
  int tx_wait = 0;
  always @(negedge clk) begin
    frame_request_t r;
    if (!rst_n) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !req_took) begin
      // Still waiting for the block to take the current request.
    end else if (tx_wait > 0) begin
      tx_wait--;
      in_valid_i <= 1'b0;
    end else if (pending_requests.size() != 0) begin
      r = pending_requests.pop_front();
      op_i        <= r.op;
      func_code_i <= r.func;
      frame_len_i <= r.len;
      data_byte_i <= r.data;
      in_valid_i  <= 1'b1;
      tx_wait = idle_draw();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: a fresh stall length is drawn after each byte taken, and a
  // requested hold-off is counted down here before anything else.
  int rx_wait = 0;
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (byte_took) rx_wait = idle_draw();
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: outputs are checked before the request of the same edge is
  // predicted, as that request cannot have produced anything yet.
  always @(posedge clk) begin
    frame_request_t r;
    frame_byte_t    e;
    req_took  <= rst_n && in_valid_i && !in_stall_o;
    byte_took <= rst_n && out_valid_o && !out_stall_i;
    if (rst_n) begin
      if (cfg_we_i) dest_q = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) begin
        if (due_bytes.size() == 0) begin
          $display("%0t: unexpected byte %02h (frame_end %0b)", $time, out_byte_o,
                   frame_end_o);
          fails++;
        end else begin
          e = due_bytes.pop_front();
          if (out_byte_o !== e.value) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, e.value,
                     out_byte_o);
            fails++;
          end
          if (frame_end_o !== e.closes) begin
            $display("%0t: frame_end expected %0b actual %0b", $time, e.closes,
                     frame_end_o);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        r.op   = op_i;
        r.func = func_code_i;
        r.len  = frame_len_i;
        r.data = data_byte_i;
        predict_frame_bytes(r);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests at the reset destination byte.
    push_start(8'h00, 8'd0);                 // empty payload: header and checks
    push_data(8'h11);                        // stray byte with no frame open
    push_start(8'hFF, tfb_pkg::byte_t'(MaxPayload + 1)); // just over the limit
    push_start(8'h80, 8'd255);               // largest length, dropped
    push_start(8'h01, 8'd1);
    push_data(8'hFF);
    push_start(8'h7F, 8'd2);
    push_data(8'h00);
    push_start(8'h55, 8'd200);               // oversized while a frame is open
    push_data(8'hFF);                        // the open frame still closes
    push_start(8'hC3, 8'd3);
    push_data(8'h01);
    push_start(8'h3C, 8'd0);                 // abandons the open frame
    push_start(8'hAA, 8'd4);
    repeat (4) push_data(8'hFF);             // both checks wrap round
    push_data(8'h22);                        // stray byte after the close
    wait_drained();

    write_dest(8'h00);
    push_random_frames(120);
    wait_drained();

    // Full rate on both sides, with a long receiver hold-off while the sender
    // keeps offering, so that the block backs up and stalls its input.
    write_dest(8'hFF);
    idle_on = 1'b0;
    hold_asks++;
    push_random_frames(100);
    wait_drained();
    idle_on = 1'b1;

    write_dest(tfb_pkg::byte_t'($urandom));
    push_random_frames(120);
    wait_drained();

    write_dest(tfb_pkg::byte_t'($urandom_range(1, 254)));
    push_random_frames(50);
    wait_drained();
    push_random_frames(50);
    wait_drained();

    if (fails == 0) begin
      $display("telemetry_frame_builder_tb: PASS");
    end else begin
      $display("telemetry_frame_builder_tb: FAIL");
    end
    $finish;
  end

  // Several times the slowest correct run.
  initial begin
    #2000000;
    $display("telemetry_frame_builder_tb: FAIL");
    $finish;
  end

endmodule

/* telemetry_frame_builder.f */
+incdir+design
design/tfb_pkg.sv
design/tfb_frame_logic.sv
design/tfb_out_buffer.sv
design/telemetry_frame_builder.sv
bench/telemetry_frame_builder_tb.sv
